### sv/temporal_soften_threshold_average_assert.svh
// ----------------------------------------------------------------------------
// Temporal soften assertion macros
// Shared concurrent assertion forms for the temporal soften checkers.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_SOFTEN_THRESHOLD_AVERAGE_ASSERT_SVH
`define TEMPORAL_SOFTEN_THRESHOLD_AVERAGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSTA_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSTA_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tsta_pkg.sv
// ----------------------------------------------------------------------------
// Temporal soften package
// Shared constants, item types, reciprocal tables and lane helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tsta_pkg;

    localparam int LANES      = 8;
    localparam int MAX_FRAMES = 16;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 20;
    localparam int COUNT_W    = 5;
    localparam int THRESH_W   = 16;
    localparam int MODE_W     = 2;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Queue depths (powers of two, pointers wrap naturally)
    localparam int JOBQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 2;

    // Depth modes; codes two and three both run 16-bit arithmetic
    localparam logic [MODE_W-1:0] MODE_8BIT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_10BIT = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEPTH_MODE  = 2'd2;

    // Fixed-point reciprocal layout
    localparam int WIDE_SHIFT     = 40;
    localparam int RECIP_SPLIT    = WIDE_SHIFT / 2;
    localparam int RECIP_WIDE_W   = WIDE_SHIFT + 1;
    localparam int RECIP_NARROW_W = 17;
    localparam int NARROW_SHIFT   = 16;
    localparam int WHI_W          = SUM_W + RECIP_WIDE_W - RECIP_SPLIT;
    localparam int WLO_W          = SUM_W + RECIP_SPLIT;
    localparam int NAR_W          = SUM_W + RECIP_NARROW_W;
    localparam int NQ_W           = NAR_W - NARROW_SHIFT;
    localparam int WQ_W           = WHI_W + 1 - RECIP_SPLIT;
    localparam int PIX8_MAX       = 255;
    localparam int PIX_MAX        = 65535;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SUM_W-1:0]    sum_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] lane_sample_0;
        logic [SAMPLE_W-1:0] lane_sample_1;
        logic [SAMPLE_W-1:0] lane_sample_2;
        logic [SAMPLE_W-1:0] lane_sample_3;
        logic [SAMPLE_W-1:0] lane_sample_4;
        logic [SAMPLE_W-1:0] lane_sample_5;
        logic [SAMPLE_W-1:0] lane_sample_6;
        logic [SAMPLE_W-1:0] lane_sample_7;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] soft_pixel_0;
        logic [SAMPLE_W-1:0] soft_pixel_1;
        logic [SAMPLE_W-1:0] soft_pixel_2;
        logic [SAMPLE_W-1:0] soft_pixel_3;
        logic [SAMPLE_W-1:0] soft_pixel_4;
        logic [SAMPLE_W-1:0] soft_pixel_5;
        logic [SAMPLE_W-1:0] soft_pixel_6;
        logic [SAMPLE_W-1:0] soft_pixel_7;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  frame_count;
        logic [THRESH_W-1:0] threshold;
        logic [MODE_W-1:0]   depth_mode;
    } cfg_t;

    // Finished group sums waiting for the divide stage
    typedef struct packed {
        sum_t [LANES-1:0]   sums;
        logic [IDX_W-1:0]   n_idx;
        logic [MODE_W-1:0]  mode;
    } job_t;

    // Clip frame count into 1..MAX_FRAMES
    function automatic logic [COUNT_W-1:0] eff_count(logic [COUNT_W-1:0] fc);
        logic [COUNT_W-1:0] n;
        if (fc == '0)
        begin
            n = COUNT_W'(1);
        end
        else if (fc > COUNT_W'(MAX_FRAMES))
        begin
            n = COUNT_W'(MAX_FRAMES);
        end
        else
        begin
            n = fc;
        end
        return n;
    endfunction

    function automatic sample_t sample_mask(logic [MODE_W-1:0] mode);
        sample_t m;
        if (mode == MODE_8BIT)
        begin
            m = sample_t'(16'h00FF);
        end
        else if (mode == MODE_10BIT)
        begin
            m = sample_t'(16'h03FF);
        end
        else
        begin
            m = '1;
        end
        return m;
    endfunction

    // Saturating accumulate of one sample into a lane sum
    function automatic sum_t sat_add(sum_t a, sample_t b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    // floor(2^40 / n), indexed by n-1
    function automatic logic [RECIP_WIDE_W-1:0] recip_wide(logic [IDX_W-1:0] idx);
        logic [RECIP_WIDE_W-1:0] r;
        unique case (idx)
            4'd0:    r = 41'd1099511627776;
            4'd1:    r = 41'd549755813888;
            4'd2:    r = 41'd366503875925;
            4'd3:    r = 41'd274877906944;
            4'd4:    r = 41'd219902325555;
            4'd5:    r = 41'd183251937962;
            4'd6:    r = 41'd157073089682;
            4'd7:    r = 41'd137438953472;
            4'd8:    r = 41'd122167958641;
            4'd9:    r = 41'd109951162777;
            4'd10:   r = 41'd99955602525;
            4'd11:   r = 41'd91625968981;
            4'd12:   r = 41'd84577817521;
            4'd13:   r = 41'd78536544841;
            4'd14:   r = 41'd73300775185;
            default: r = 41'd68719476736;
        endcase
        return r;
    endfunction

    // ceil(65536 / n), indexed by n-1
    function automatic logic [RECIP_NARROW_W-1:0] recip_narrow(logic [IDX_W-1:0] idx);
        logic [RECIP_NARROW_W-1:0] r;
        unique case (idx)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd32768;
            4'd2:    r = 17'd21846;
            4'd3:    r = 17'd16384;
            4'd4:    r = 17'd13108;
            4'd5:    r = 17'd10923;
            4'd6:    r = 17'd9363;
            4'd7:    r = 17'd8192;
            4'd8:    r = 17'd7282;
            4'd9:    r = 17'd6554;
            4'd10:   r = 17'd5958;
            4'd11:   r = 17'd5462;
            4'd12:   r = 17'd5042;
            4'd13:   r = 17'd4682;
            4'd14:   r = 17'd4370;
            default: r = 17'd4096;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/temporal_soften_threshold_average.sv
// ----------------------------------------------------------------------------
// Temporal soften, threshold-average mode
// Averages eight adjacent pixels over a group of frames around a center.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_item and raise push while full is low. The first
//   item of a group holds the center frame; frame_count items make a group.
//   Result queue: while empty is low, out_item holds the oldest result;
//   raise pop to take it. One result comes out per group, none otherwise.
//   Configuration: write cfg_wdata to register cfg_addr (0 frame_count,
//   1 threshold, 2 depth_mode) with cfg_we, only while the block is idle.
//   Throughput: one item per cycle while full is low. The front end
//   accumulates in the same cycle it accepts; the back end multiplies
//   in one pipeline stage and finishes each lane on its way into the
//   result queue. A group's sums pass through the job queue and the
//   multiply stage register before its result shows in the result queue.
//   Stall: when pop stays low, the two-entry result queue, the multiply
//   stage and the two-entry job queue fill; full rises once the job queue
//   holds two groups.
//   Reset: clears group position and all queues; registers return to
//   frame_count 1, threshold 0, depth_mode 8-bit.
// ----------------------------------------------------------------------------
`default_nettype none

module temporal_soften_threshold_average (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  tsta_pkg::in_item_t                  in_item,
    output logic                                empty,
    input  logic                                pop,
    output tsta_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [tsta_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tsta_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tsta_pkg::*;

    cfg_t  cfg_reg;
    logic  in_take;
    logic  job_push;
    job_t  job_in;
    job_t  job_out;
    logic  job_pop;
    logic  jobq_full;
    logic  jobq_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_count <= COUNT_W'(1);
            cfg_reg.threshold   <= '0;
            cfg_reg.depth_mode  <= MODE_8BIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FRAME_COUNT: cfg_reg.frame_count <= cfg_wdata[COUNT_W-1:0];
                CFG_THRESHOLD:   cfg_reg.threshold   <= cfg_wdata[THRESH_W-1:0];
                CFG_DEPTH_MODE:  cfg_reg.depth_mode  <= cfg_wdata[MODE_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Accept an item while the job queue has room
    assign full    = jobq_full;
    assign in_take = push & ~jobq_full;

    tsta_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .job_push (job_push),
        .job      (job_in)
    );

    tsta_job_queue u_job_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .rd_en  (job_pop),
        .rd_job (job_out),
        .full   (jobq_full),
        .empty  (jobq_empty)
    );

    tsta_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (~jobq_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

### sv/tsta_front.sv
// ----------------------------------------------------------------------------
// Temporal soften front end
// Threshold-tests each frame against the center and accumulates lane sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tsta_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_take,
    input  tsta_pkg::in_item_t in_item,
    input  tsta_pkg::cfg_t    cfg,
    output logic              job_push,
    output tsta_pkg::job_t    job
);
    import tsta_pkg::*;

    logic [IDX_W-1:0]   frame_index_reg;
    logic [IDX_W-1:0]   frame_index_next;
    sample_t [LANES-1:0] center_reg;
    sum_t [LANES-1:0]    sum_reg;
    sum_t [LANES-1:0]    sum_next;
    sample_t [LANES-1:0] lane_in;
    logic [COUNT_W-1:0] n_eff;
    logic               first;
    logic               last;
    sample_t            mask;

    // Unpack the item into lanes
    assign lane_in[0] = in_item.lane_sample_0;
    assign lane_in[1] = in_item.lane_sample_1;
    assign lane_in[2] = in_item.lane_sample_2;
    assign lane_in[3] = in_item.lane_sample_3;
    assign lane_in[4] = in_item.lane_sample_4;
    assign lane_in[5] = in_item.lane_sample_5;
    assign lane_in[6] = in_item.lane_sample_6;
    assign lane_in[7] = in_item.lane_sample_7;

    // Classify the item's place in its group
    assign n_eff = eff_count(cfg.frame_count);
    assign mask  = sample_mask(cfg.depth_mode);
    assign first = (frame_index_reg == '0);
    assign last  = (COUNT_W'(frame_index_reg) + COUNT_W'(1)) >= n_eff;
    assign frame_index_next = last ? '0 : frame_index_reg + IDX_W'(1);

    // Select center or frame sample per lane and accumulate
    always_comb
    begin
        sample_t v;
        sample_t c;
        sample_t diff;
        logic    take;
        sample_t addend;
        sum_t    base;
        for (int i = 0; i < LANES; i++)
        begin
            v    = lane_in[i] & mask;
            c    = center_reg[i] & mask;
            diff = (c > v) ? (c - v) : (v - c);
            if (cfg.depth_mode == MODE_10BIT)
            begin
                take = diff < cfg.threshold;
            end
            else
            begin
                take = diff <= cfg.threshold;
            end
            addend      = (first || take) ? v : c;
            base        = first ? SUM_W'(n_eff >> 1) : sum_reg[i];
            sum_next[i] = sat_add(base, addend);
        end
    end

    // Hand the finished group to the back end
    assign job_push  = in_take & last;
    assign job.sums  = sum_next;
    assign job.n_idx = IDX_W'(n_eff - COUNT_W'(1));
    assign job.mode  = cfg.depth_mode;

    // Advance group position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_index_reg <= '0;
        end
        else if (in_take)
        begin
            frame_index_reg <= frame_index_next;
        end
    end

    // Hold center samples and running sums
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sum_reg <= sum_next;
            if (first)
            begin
                center_reg <= lane_in;
            end
        end
    end

endmodule

`default_nettype wire

### sv/tsta_job_queue.sv
// ----------------------------------------------------------------------------
// Temporal soften job queue
// Short queue of finished group sums between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tsta_job_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tsta_pkg::job_t wr_job,
    input  logic           rd_en,
    output tsta_pkg::job_t rd_job,
    output logic           full,
    output logic           empty
);
    import tsta_pkg::*;

    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    job_t             entry_reg [JOBQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full   = (count_reg == CNT_W'(JOBQ_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

### sv/tsta_back.sv
// ----------------------------------------------------------------------------
// Temporal soften back end
// Divides lane sums by the frame count and queues result items.
// ----------------------------------------------------------------------------
`default_nettype none

module tsta_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_avail,
    input  tsta_pkg::job_t     job,
    output logic               job_pop,
    input  logic               pop,
    output logic               empty,
    output tsta_pkg::out_item_t out_item
);
    import tsta_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Multiply stage
    logic                   s1_valid_reg;
    logic [WHI_W-1:0]       s1_hi_reg   [LANES];
    logic [WHI_W-1:0]       s1_hi_next  [LANES];
    logic [WLO_W-1:0]       s1_lo_reg   [LANES];
    logic [WLO_W-1:0]       s1_lo_next  [LANES];
    logic [NAR_W-1:0]       s1_nar_reg  [LANES];
    logic [NAR_W-1:0]       s1_nar_next [LANES];
    sum_t [LANES-1:0]       s1_sum_reg;
    logic [IDX_W-1:0]       s1_idx_reg;
    logic [MODE_W-1:0]      s1_mode_reg;
    logic [RECIP_WIDE_W-1:0]   rw;
    logic [RECIP_NARROW_W-1:0] rn;

    // Result queue
    out_item_t              outq_reg [OUTQ_DEPTH];
    logic [PTR_W-1:0]       owr_ptr_reg;
    logic [PTR_W-1:0]       ord_ptr_reg;
    logic [CNT_W-1:0]       ocount_reg;
    logic [CNT_W-1:0]       ocount_next;
    sample_t [LANES-1:0]    pix;
    out_item_t              result;

    logic out_pop;
    logic out_room;
    logic s1_move;
    logic s1_load;

    // Flow control: the multiply stage moves when the result queue has room
    assign out_pop  = pop & ~empty;
    assign out_room = (ocount_reg != CNT_W'(OUTQ_DEPTH)) || out_pop;
    assign s1_move  = s1_valid_reg & out_room;
    assign s1_load  = ~s1_valid_reg | s1_move;
    assign job_pop  = job_avail & s1_load;

    // Split products against the reciprocals
    assign rw = recip_wide(job.n_idx);
    assign rn = recip_narrow(job.n_idx);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            s1_hi_next[i]  = WHI_W'(job.sums[i]) * WHI_W'(rw[RECIP_WIDE_W-1:RECIP_SPLIT]);
            s1_lo_next[i]  = WLO_W'(job.sums[i]) * WLO_W'(rw[RECIP_SPLIT-1:0]);
            s1_nar_next[i] = NAR_W'(job.sums[i]) * NAR_W'(rn);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= job_avail;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_hi_reg   <= s1_hi_next;
            s1_lo_reg   <= s1_lo_next;
            s1_nar_reg  <= s1_nar_next;
            s1_sum_reg  <= job.sums;
            s1_idx_reg  <= job.n_idx;
            s1_mode_reg <= job.mode;
        end
    end

    // Finish: round, shift and clamp each lane
    always_comb
    begin
        logic [WLO_W:0]    lo_round;
        logic [WHI_W:0]    wide_sum;
        logic [WQ_W-1:0]   wide_q;
        logic [NQ_W-1:0]   nar_q;
        logic              narrow_mode;
        narrow_mode = (s1_mode_reg == MODE_8BIT) || (s1_mode_reg == MODE_10BIT);
        for (int i = 0; i < LANES; i++)
        begin
            lo_round = (WLO_W+1)'(s1_lo_reg[i]) + ((WLO_W+1)'(1) << RECIP_SPLIT);
            wide_sum = (WHI_W+1)'(s1_hi_reg[i]) + (WHI_W+1)'(lo_round[WLO_W:RECIP_SPLIT]);
            wide_q   = wide_sum[WHI_W:RECIP_SPLIT];
            if (s1_idx_reg <= IDX_W'(1))
            begin
                nar_q = NQ_W'(s1_sum_reg[i] >> s1_idx_reg);
            end
            else
            begin
                nar_q = s1_nar_reg[i][NAR_W-1:NARROW_SHIFT];
            end
            if (narrow_mode)
            begin
                if ((s1_mode_reg == MODE_8BIT) && (nar_q > NQ_W'(PIX8_MAX)))
                begin
                    pix[i] = sample_t'(PIX8_MAX);
                end
                else if (nar_q > NQ_W'(PIX_MAX))
                begin
                    pix[i] = sample_t'(PIX_MAX);
                end
                else
                begin
                    pix[i] = nar_q[SAMPLE_W-1:0];
                end
            end
            else if (wide_q > WQ_W'(PIX_MAX))
            begin
                pix[i] = sample_t'(PIX_MAX);
            end
            else
            begin
                pix[i] = wide_q[SAMPLE_W-1:0];
            end
        end
    end

    // Pack lanes into the result item
    assign result.soft_pixel_0 = pix[0];
    assign result.soft_pixel_1 = pix[1];
    assign result.soft_pixel_2 = pix[2];
    assign result.soft_pixel_3 = pix[3];
    assign result.soft_pixel_4 = pix[4];
    assign result.soft_pixel_5 = pix[5];
    assign result.soft_pixel_6 = pix[6];
    assign result.soft_pixel_7 = pix[7];

    // Result queue occupancy
    assign empty    = (ocount_reg == '0);
    assign out_item = outq_reg[ord_ptr_reg];

    always_comb
    begin
        ocount_next = ocount_reg;
        if (s1_move && !out_pop)
        begin
            ocount_next = ocount_reg + CNT_W'(1);
        end
        else if (out_pop && !s1_move)
        begin
            ocount_next = ocount_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            ocount_reg <= ocount_next;
            if (s1_move)
            begin
                owr_ptr_reg <= owr_ptr_reg + PTR_W'(1);
            end
            if (out_pop)
            begin
                ord_ptr_reg <= ord_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            outq_reg[owr_ptr_reg] <= result;
        end
    end

endmodule

`default_nettype wire

### sv/tsta_checker.sv
// ----------------------------------------------------------------------------
// Temporal soften port checker
// Tracks group ends at the ports and checks result ordering and flow.
// ----------------------------------------------------------------------------
`default_nettype none

`include "temporal_soften_threshold_average_assert.svh"

module tsta_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic                            full,
    input  logic                            empty,
    input  logic                            pop,
    input  tsta_pkg::out_item_t             out_item,
    input  logic                            cfg_we,
    input  logic [tsta_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tsta_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tsta_pkg::*;

    logic [COUNT_W-1:0] fc_reg;
    logic [IDX_W-1:0]   fi_reg;
    logic [3:0]         pend_reg;
    logic               in_take;
    logic               out_take;
    logic               group_end;

    assign in_take   = push & ~full;
    assign out_take  = pop & ~empty;
    assign group_end = in_take &&
        ((COUNT_W'(fi_reg) + COUNT_W'(1)) >= eff_count(fc_reg));

    // Mirror the frame count, group position and results owed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg   <= COUNT_W'(1);
            fi_reg   <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == CFG_FRAME_COUNT))
            begin
                fc_reg <= cfg_wdata[COUNT_W-1:0];
            end
            if (in_take)
            begin
                fi_reg <= group_end ? '0 : fi_reg + IDX_W'(1);
            end
            pend_reg <= pend_reg + 4'(group_end) - 4'(out_take);
        end
    end

    // No result is shown before its group ends
    `TSTA_ASSERT_NOW(a_no_early_result, clk, rst_n, pend_reg == 4'd0, empty,
        "result shown with no finished group")

    // The oldest finished group reaches the result port through the job queue and multiply stage
    `TSTA_ASSERT_NOW(a_result_arrives, clk, rst_n,
        (pend_reg != 4'd0) && $past(pend_reg != 4'd0) && $past(pend_reg != 4'd0, 2) &&
        $past(!out_take) && $past(!out_take, 2),
        !empty, "finished group not delivered")

    // Back pressure only when two groups are already owed
    `TSTA_ASSERT_NOW(a_full_owed, clk, rst_n, full, pend_reg >= 4'd2,
        "full raised without queued groups")

    // A stalled result holds
    `TSTA_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop,
        !empty && $stable(out_item), "stalled result changed")

endmodule

bind temporal_soften_threshold_average tsta_checker u_checker (.*);

`default_nettype wire
